[design/dldq_pkg.sv]
// ----------------------------------------------------------------------------
// dldq_pkg
// Shared sizes, codes and types of the delta-list delay queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dldq_pkg;

	localparam int DEPTH       = 16;
	localparam int HANDLE_BITS = 16;
	localparam int DELTA_W     = 32;
	localparam int PTR_W       = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int KIND_W      = 2;
	localparam int RES_W       = 3;
	localparam int IN_DATA_W   = 48;

	typedef logic [PTR_W-1:0]       ptr_t;
	typedef logic [CNT_W-1:0]       cnt_t;
	typedef logic [DELTA_W-1:0]     delta_t;
	typedef logic [HANDLE_BITS-1:0] handle_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 2'd0,
		KIND_TICK   = 2'd1,
		KIND_DRAIN  = 2'd2
	} in_kind_t;

	typedef enum logic [RES_W-1:0] {
		RES_ACCEPTED = 3'd0,
		RES_FULL     = 3'd1,
		RES_CLOSED   = 3'd2,
		RES_EXPIRED  = 3'd3,
		RES_DRAINED  = 3'd4
	} res_kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISP,
		ST_REPLY,
		ST_INS_WALK,
		ST_INS_END,
		ST_TK_HEAD,
		ST_TK_POP,
		ST_TK_FLUSH,
		ST_DRN
	} state_t;

	// one access set for both entry memories (same slot in each)
	typedef struct packed {
		logic    rd_en;
		ptr_t    rd_addr;
		logic    wr_en;
		ptr_t    wr_addr;
		delta_t  wr_delta;
		handle_t wr_handle;
	} mem_req_t;

	// list position to memory slot, circular from the head slot
	function automatic ptr_t slot(input ptr_t head, input ptr_t off);
		logic [PTR_W:0] sum;
		sum = {1'b0, head} + {1'b0, off};
		if (sum >= (PTR_W+1)'(DEPTH))
			sum = sum - (PTR_W+1)'(DEPTH);
		return sum[PTR_W-1:0];
	endfunction

endpackage

`default_nettype wire

[design/dldq_ram.sv]
// ----------------------------------------------------------------------------
// dldq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dldq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

[design/dldq_ctrl.sv]
// ----------------------------------------------------------------------------
// dldq_ctrl
// Sequencer of the delay queue: walks the delta list held in the entry
// memories for inserts, ticks and drains, and owns the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dldq_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [dldq_pkg::KIND_W-1:0] in_kind,
	input  wire dldq_pkg::handle_t           in_handle,
	input  wire dldq_pkg::delta_t            in_delay,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output dldq_pkg::res_kind_t              out_kind,
	output dldq_pkg::handle_t                out_handle,
	output logic                             out_last,
	output dldq_pkg::mem_req_t               mem_req,
	input  wire dldq_pkg::delta_t            rd_delta,
	input  wire dldq_pkg::handle_t           rd_handle
);

	import dldq_pkg::*;

	state_t    state_q, state_d;
	logic [KIND_W-1:0] kind_q;
	handle_t   handle_q;
	delta_t    rem_q;
	ptr_t      head_q;
	cnt_t      count_q;
	logic      accepting_q;
	ptr_t      j_q;
	logic      searching_q;
	delta_t    carry_d_q;
	handle_t   carry_h_q;
	handle_t   pend_h_q;
	res_kind_t reply_q;

	logic      m_valid_q;
	res_kind_t m_kind_q;
	handle_t   m_handle_q;
	logic      m_last_q;

	logic      out_free;
	logic      j_last;
	logic      ins_ge;
	logic      d_zero;
	logic      d_big;
	logic      one_left;
	logic      is_full;
	logic      emit;
	res_kind_t emit_kind;
	handle_t   emit_handle;
	logic      emit_last;

	assign out_free = !m_valid_q || out_ready;
	assign j_last   = (CNT_W'(j_q) == count_q - CNT_W'(1));
	assign ins_ge   = (rem_q >= rd_delta);
	assign d_zero   = (rd_delta == '0);
	assign d_big    = (rd_delta > DELTA_W'(1));
	assign one_left = (count_q == CNT_W'(1));
	assign is_full  = (count_q == CNT_W'(DEPTH));
	assign in_ready = (state_q == ST_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = ST_DISP;
			end
			ST_DISP: begin
				case (kind_q)
					KIND_INSERT: begin
						if (!accepting_q || is_full)
							state_d = ST_REPLY;
						else if (count_q == '0)
							state_d = ST_INS_END;
						else
							state_d = ST_INS_WALK;
					end
					KIND_TICK: begin
						state_d = (accepting_q && count_q != '0) ? ST_TK_HEAD : ST_IDLE;
					end
					KIND_DRAIN: begin
						state_d = (accepting_q && count_q != '0) ? ST_DRN : ST_IDLE;
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_INS_WALK: begin
				if (j_last)
					state_d = ST_INS_END;
			end
			ST_INS_END, ST_REPLY, ST_TK_FLUSH: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			ST_TK_HEAD: begin
				if (d_big)
					state_d = ST_IDLE;
				else if (one_left)
					state_d = ST_TK_FLUSH;
				else
					state_d = ST_TK_POP;
			end
			ST_TK_POP: begin
				if (out_free) begin
					if (!d_zero)
						state_d = ST_IDLE;
					else if (one_left)
						state_d = ST_TK_FLUSH;
				end
			end
			ST_DRN: begin
				if (out_free && j_last)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory accesses and result emission
	always_comb begin
		mem_req     = '0;
		emit        = 1'b0;
		emit_kind   = RES_ACCEPTED;
		emit_handle = '0;
		emit_last   = 1'b0;
		case (state_q)
			ST_DISP: begin
				mem_req.rd_addr = head_q;
				case (kind_q)
					KIND_INSERT: mem_req.rd_en = accepting_q && !is_full && count_q != '0;
					KIND_TICK, KIND_DRAIN: mem_req.rd_en = accepting_q && count_q != '0;
					default: mem_req.rd_en = 1'b0;
				endcase
			end
			ST_INS_WALK: begin
				// read one ahead while the current entry is placed or shifted
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = slot(head_q, j_q + PTR_W'(1));
				mem_req.wr_en   = !(searching_q && ins_ge);
				mem_req.wr_addr = slot(head_q, j_q);
				if (searching_q) begin
					mem_req.wr_delta  = rem_q;
					mem_req.wr_handle = handle_q;
				end else begin
					mem_req.wr_delta  = carry_d_q;
					mem_req.wr_handle = carry_h_q;
				end
			end
			ST_INS_END: begin
				mem_req.wr_en   = out_free;
				mem_req.wr_addr = slot(head_q, count_q[PTR_W-1:0]);
				if (searching_q) begin
					mem_req.wr_delta  = rem_q;
					mem_req.wr_handle = handle_q;
				end else begin
					mem_req.wr_delta  = carry_d_q;
					mem_req.wr_handle = carry_h_q;
				end
				emit      = out_free;
				emit_kind = RES_ACCEPTED;
				emit_last = 1'b1;
			end
			ST_REPLY: begin
				emit      = out_free;
				emit_kind = reply_q;
				emit_last = 1'b1;
			end
			ST_TK_HEAD: begin
				mem_req.wr_en     = d_big;
				mem_req.wr_addr   = head_q;
				mem_req.wr_delta  = rd_delta - DELTA_W'(1);
				mem_req.wr_handle = rd_handle;
				mem_req.rd_en     = !d_big && !one_left;
				mem_req.rd_addr   = slot(head_q, PTR_W'(1));
			end
			ST_TK_POP: begin
				// the previous expiry is last unless the new head is also due
				emit            = out_free;
				emit_kind       = RES_EXPIRED;
				emit_handle     = pend_h_q;
				emit_last       = !d_zero;
				mem_req.rd_en   = out_free && d_zero && !one_left;
				mem_req.rd_addr = slot(head_q, PTR_W'(1));
			end
			ST_TK_FLUSH: begin
				emit        = out_free;
				emit_kind   = RES_EXPIRED;
				emit_handle = pend_h_q;
				emit_last   = 1'b1;
			end
			ST_DRN: begin
				emit            = out_free;
				emit_kind       = RES_DRAINED;
				emit_handle     = rd_handle;
				emit_last       = j_last;
				mem_req.rd_en   = out_free && !j_last;
				mem_req.rd_addr = slot(head_q, j_q + PTR_W'(1));
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			accepting_q <= 1'b1;
			m_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit)
				m_valid_q <= 1'b1;
			else if (out_ready)
				m_valid_q <= 1'b0;
			case (state_q)
				ST_DISP: begin
					if (kind_q == KIND_DRAIN)
						accepting_q <= 1'b0;
				end
				ST_INS_END: begin
					if (out_free)
						count_q <= count_q + CNT_W'(1);
				end
				ST_TK_HEAD: begin
					if (!d_big) begin
						head_q  <= slot(head_q, PTR_W'(1));
						count_q <= count_q - CNT_W'(1);
					end
				end
				ST_TK_POP: begin
					if (out_free && d_zero) begin
						head_q  <= slot(head_q, PTR_W'(1));
						count_q <= count_q - CNT_W'(1);
					end
				end
				ST_DRN: begin
					if (out_free && j_last)
						count_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// working registers and result payload
	always_ff @(posedge clk) begin
		if (emit) begin
			m_kind_q   <= emit_kind;
			m_handle_q <= emit_handle;
			m_last_q   <= emit_last;
		end
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					kind_q      <= in_kind;
					handle_q    <= in_handle;
					rem_q       <= in_delay;
					j_q         <= '0;
					searching_q <= 1'b1;
				end
			end
			ST_DISP: begin
				reply_q <= accepting_q ? RES_FULL : RES_CLOSED;
			end
			ST_INS_WALK: begin
				j_q <= j_q + PTR_W'(1);
				if (searching_q && ins_ge) begin
					rem_q <= rem_q - rd_delta;
				end else if (searching_q) begin
					searching_q <= 1'b0;
					carry_d_q   <= rd_delta - rem_q;
					carry_h_q   <= rd_handle;
				end else begin
					carry_d_q <= rd_delta;
					carry_h_q <= rd_handle;
				end
			end
			ST_TK_HEAD: begin
				pend_h_q <= rd_handle;
			end
			ST_TK_POP: begin
				if (out_free && d_zero)
					pend_h_q <= rd_handle;
			end
			ST_DRN: begin
				if (out_free)
					j_q <= j_q + PTR_W'(1);
			end
			default: ;
		endcase
	end

	assign out_valid  = m_valid_q;
	assign out_kind   = m_kind_q;
	assign out_handle = m_handle_q;
	assign out_last   = m_last_q;

endmodule

`default_nettype wire

[design/delta_list_delay_queue_top.sv]
// ----------------------------------------------------------------------------
// delta_list_delay_queue_top
// Delay queue kept as an ordered delta list in two entry memories.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                          | tuser            | tlast
//  s_      | in  | [15:0] handle, [47:16] delay_ms | [1:0] kind       | -
//  m_      | out | [15:0] handle_res              | [2:0] result_kind | last
//
//  Insert: one list entry per cycle over the held entries (bound by the
//  single memory read port), then the result is placed.
//  Tick: lowers the head delta, or expires the head and each following
//  zero-delta entry. Drain: returns every entry. Refused inserts reply.
//  A stalled result register holds the sequencer; the memories need no
//  clearing after reset, the block is ready at once.
// ----------------------------------------------------------------------------
`default_nettype none

module delta_list_delay_queue_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,  // [15:0] handle, [47:16] delay_ms
	input  wire logic [1:0]  s_tuser,  // [1:0] kind
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,  // [15:0] handle_res
	output logic [2:0]       m_tuser,  // [2:0] result_kind
	output logic             m_tlast
);

	import dldq_pkg::*;

	mem_req_t  mem_req;
	delta_t    rd_delta;
	handle_t   rd_handle;
	res_kind_t out_kind;

	dldq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_kind    (s_tuser),
		.in_handle  (s_tdata[HANDLE_BITS-1:0]),
		.in_delay   (s_tdata[IN_DATA_W-1:16]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_kind   (out_kind),
		.out_handle (m_tdata),
		.out_last   (m_tlast),
		.mem_req    (mem_req),
		.rd_delta   (rd_delta),
		.rd_handle  (rd_handle)
	);

	assign m_tuser = out_kind;

	dldq_ram #(
		.WIDTH (DELTA_W),
		.DEPTH (DEPTH)
	) u_delta_ram (
		.clk     (clk),
		.wr_en   (mem_req.wr_en),
		.wr_addr (mem_req.wr_addr),
		.wr_data (mem_req.wr_delta),
		.rd_en   (mem_req.rd_en),
		.rd_addr (mem_req.rd_addr),
		.rd_data (rd_delta)
	);

	dldq_ram #(
		.WIDTH (HANDLE_BITS),
		.DEPTH (DEPTH)
	) u_handle_ram (
		.clk     (clk),
		.wr_en   (mem_req.wr_en),
		.wr_addr (mem_req.wr_addr),
		.wr_data (mem_req.wr_handle),
		.rd_en   (mem_req.rd_en),
		.rd_addr (mem_req.rd_addr),
		.rd_data (rd_handle)
	);

endmodule

`default_nettype wire
